[rtl/deq_pkg.sv]
// Shared types and constants for the double-ended queue core.
// Holds request kinds, result status codes, the decoded command and back-end states.
// No dependencies.
`default_nettype none

package deq_pkg;

   localparam int DEQ_DEPTH = 32;
   localparam int VALUE_W   = 32;
   localparam int KIND_W    = 3;
   localparam int STATUS_W  = 2;
   localparam int COUNT_W   = 6;

   // Request kind codes as they arrive on the bus
   localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd0;
   localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 3'd1;
   localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd2;
   localparam logic [KIND_W-1:0] KIND_POP_BACK   = 3'd3;
   localparam logic [KIND_W-1:0] KIND_LIST       = 3'd4;

   // Result status codes
   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

   typedef enum logic [2:0] {
      OP_PUSH_FRONT,
      OP_PUSH_BACK,
      OP_POP_FRONT,
      OP_POP_BACK,
      OP_LIST
   } op_type;

   typedef struct packed {
      op_type             op;
      logic [VALUE_W-1:0] value;
   } cmd_type;

   typedef enum logic [1:0] {
      BACK_IDLE,
      BACK_POP_WAIT,
      BACK_LIST_WAIT,
      BACK_LIST_NEXT
   } back_state_type;

endpackage

`default_nettype wire

[rtl/deq_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Standalone; holds the ring entries of the queue.
`default_nettype none

module deq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[rtl/deq_front.sv]
// Front end: accepts requests, decodes the kind and queues commands for the back end.
// Uses deq_pkg for kind codes and the command struct.
`default_nettype none

module deq_front (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   input  wire logic [deq_pkg::VALUE_W-1:0]    req_value,
   input  wire logic [deq_pkg::KIND_W-1:0]     req_kind,
   output logic                                cmd_valid,
   output deq_pkg::cmd_type                    cmd,
   input  wire logic                           cmd_ready
);

   import deq_pkg::*;

   cmd_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;

   logic       kind_ok;
   op_type     kind_op;
   logic       push;
   logic       pop;

   // Decode the request kind; unused kinds are dropped
   always_comb begin
      kind_ok = 1'b1;
      kind_op = OP_LIST;
      case (req_kind)
         KIND_PUSH_FRONT: kind_op = OP_PUSH_FRONT;
         KIND_PUSH_BACK:  kind_op = OP_PUSH_BACK;
         KIND_POP_FRONT:  kind_op = OP_POP_FRONT;
         KIND_POP_BACK:   kind_op = OP_POP_BACK;
         KIND_LIST:       kind_op = OP_LIST;
         default:         kind_ok = 1'b0;
      endcase
   end

   assign req_tready = (fill_ff != 2'd2);
   assign push       = req_tvalid && req_tready && kind_ok;
   assign cmd_valid  = (fill_ff != 2'd0);
   assign pop        = cmd_valid && cmd_ready;
   assign cmd        = slot_ff[rd_ptr_ff];

   // Advance queue pointers and fill level
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Hold queued commands
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= '{op: kind_op, value: req_value};
      end
   end

endmodule

`default_nettype wire

[rtl/deq_back.sv]
// Back end: executes queued commands on the ring and drives the result register.
// Uses deq_pkg for ops, status codes and states; drives the element RAM ports.
`default_nettype none

module deq_back #(
   parameter int DEPTH = deq_pkg::DEQ_DEPTH
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            cmd_valid,
   input  wire deq_pkg::cmd_type                cmd,
   output logic                                 cmd_ready,
   output logic                                 ram_wr_en,
   output logic [$clog2(DEPTH)-1:0]             ram_wr_addr,
   output logic [deq_pkg::VALUE_W-1:0]          ram_wr_data,
   output logic                                 ram_rd_en,
   output logic [$clog2(DEPTH)-1:0]             ram_rd_addr,
   input  wire logic [deq_pkg::VALUE_W-1:0]     ram_rd_data,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic [deq_pkg::VALUE_W-1:0]          rsp_value,
   output logic [deq_pkg::STATUS_W-1:0]         rsp_status,
   output logic [deq_pkg::COUNT_W-1:0]          rsp_count,
   output logic                                 rsp_last
);

   import deq_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   back_state_type     state_ff, state_in;
   logic [PTR_W-1:0]   head_ff, head_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   idx_ff, idx_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0] rsp_value_ff, rsp_value_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [COUNT_W-1:0] rsp_count_ff, rsp_count_in;
   logic               rsp_last_ff, rsp_last_in;

   logic               out_free;
   logic               start;
   logic               is_full;
   logic               is_empty;
   logic               last_elem;
   logic [CNT_W-1:0]   count_dec;
   logic [PTR_W-1:0]   head_dec;

   // Add an offset to a ring index, wrapping once at the depth
   function automatic logic [PTR_W-1:0] ring_add(input logic [PTR_W-1:0] base,
                                                 input logic [PTR_W-1:0] off);
      logic [PTR_W:0] sum;
      sum = {1'b0, base} + {1'b0, off};
      if (sum >= (PTR_W + 1)'(DEPTH)) begin
         sum = sum - (PTR_W + 1)'(DEPTH);
      end
      return sum[PTR_W-1:0];
   endfunction

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign start     = (state_ff == BACK_IDLE) && cmd_valid && out_free;
   assign is_full   = (count_ff == CNT_W'(DEPTH));
   assign is_empty  = (count_ff == '0);
   assign count_dec = count_ff - 1'b1;
   assign last_elem = (CNT_W'(idx_ff + 1'b1) == count_ff);
   assign head_dec  = (head_ff == '0) ? PTR_W'(DEPTH - 1) : head_ff - 1'b1;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BACK_IDLE: begin
            if (start && !is_empty &&
                (cmd.op == OP_POP_FRONT || cmd.op == OP_POP_BACK)) begin
               state_in = BACK_POP_WAIT;
            end else if (start && !is_empty && cmd.op == OP_LIST) begin
               state_in = BACK_LIST_WAIT;
            end
         end
         BACK_POP_WAIT: state_in = BACK_IDLE;
         BACK_LIST_WAIT: begin
            state_in = last_elem ? BACK_IDLE : BACK_LIST_NEXT;
         end
         BACK_LIST_NEXT: begin
            if (out_free) begin
               state_in = BACK_LIST_WAIT;
            end
         end
         default: state_in = BACK_IDLE;
      endcase
   end

   // Ring updates, RAM access and result loading
   always_comb begin
      head_in       = head_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      cmd_ready     = 1'b0;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = head_ff;
      ram_wr_data   = cmd.value;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = head_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_last_in   = rsp_last_ff;
      case (state_ff)
         BACK_IDLE: begin
            if (start) begin
               cmd_ready = 1'b1;
               case (cmd.op)
                  OP_PUSH_FRONT, OP_PUSH_BACK: begin
                     rsp_valid_in = 1'b1;
                     rsp_value_in = '0;
                     rsp_last_in  = 1'b1;
                     if (is_full) begin
                        rsp_status_in = STATUS_FULL;
                        rsp_count_in  = COUNT_W'(count_ff);
                     end else begin
                        ram_wr_en = 1'b1;
                        if (cmd.op == OP_PUSH_FRONT) begin
                           ram_wr_addr = head_dec;
                           head_in     = head_dec;
                        end else begin
                           ram_wr_addr = ring_add(head_ff, count_ff[PTR_W-1:0]);
                        end
                        count_in      = count_ff + 1'b1;
                        rsp_status_in = STATUS_OK;
                        rsp_count_in  = COUNT_W'(count_in);
                     end
                  end
                  OP_POP_FRONT, OP_POP_BACK: begin
                     if (is_empty) begin
                        rsp_valid_in  = 1'b1;
                        rsp_value_in  = '0;
                        rsp_status_in = STATUS_EMPTY;
                        rsp_count_in  = '0;
                        rsp_last_in   = 1'b1;
                     end else begin
                        ram_rd_en = 1'b1;
                        if (cmd.op == OP_POP_FRONT) begin
                           ram_rd_addr = head_ff;
                           head_in     = ring_add(head_ff, PTR_W'(1));
                        end else begin
                           ram_rd_addr = ring_add(head_ff, count_dec[PTR_W-1:0]);
                        end
                        count_in = count_dec;
                     end
                  end
                  OP_LIST: begin
                     if (is_empty) begin
                        rsp_valid_in  = 1'b1;
                        rsp_value_in  = '0;
                        rsp_status_in = STATUS_EMPTY;
                        rsp_count_in  = '0;
                        rsp_last_in   = 1'b1;
                     end else begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = head_ff;
                        idx_in      = '0;
                     end
                  end
                  default: begin
                     cmd_ready = 1'b1;
                  end
               endcase
            end
         end
         BACK_POP_WAIT: begin
            rsp_valid_in  = 1'b1;
            rsp_value_in  = ram_rd_data;
            rsp_status_in = STATUS_OK;
            rsp_count_in  = COUNT_W'(count_ff);
            rsp_last_in   = 1'b1;
         end
         BACK_LIST_WAIT: begin
            rsp_valid_in  = 1'b1;
            rsp_value_in  = ram_rd_data;
            rsp_status_in = STATUS_OK;
            rsp_count_in  = COUNT_W'(count_ff);
            rsp_last_in   = last_elem;
            idx_in        = idx_ff + 1'b1;
         end
         BACK_LIST_NEXT: begin
            if (out_free) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = ring_add(head_ff, idx_ff[PTR_W-1:0]);
            end
         end
         default: begin
            rsp_valid_in = rsp_valid_ff && !rsp_ready;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BACK_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload and list index
   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_value  = rsp_value_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_count  = rsp_count_ff;
   assign rsp_last   = rsp_last_ff;

endmodule

`default_nettype wire

[rtl/double_ended_queue_core.sv]
// Double-ended queue core: bounded ring of signed 32-bit values behind stream ports.
// Results pass through the 2-entry command queue and the result register; pops and listed
// elements also pass through the registered RAM read.
// Throughput: one push per cycle while the result port is not stalled; a pop or a list element
// holds the back end in a wait state for the registered RAM read, so no new command is taken meanwhile.
// Reset (synchronous): empties the queue; RAM contents are not cleared and need no pass.
`default_nettype none

module double_ended_queue_core #(
   parameter int DEPTH = deq_pkg::DEQ_DEPTH
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // [31:0] value
   input  wire logic [2:0]  req_tuser,   // [2:0] kind
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata,   // [31:0] value_res, [33:32] status, [39:34] element_count
   output logic             rsp_tlast
);

   import deq_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);

   logic                cmd_valid;
   cmd_type             cmd;
   logic                cmd_ready;
   logic                ram_wr_en;
   logic [PTR_W-1:0]    ram_wr_addr;
   logic [VALUE_W-1:0]  ram_wr_data;
   logic                ram_rd_en;
   logic [PTR_W-1:0]    ram_rd_addr;
   logic [VALUE_W-1:0]  ram_rd_data;
   logic [VALUE_W-1:0]  rsp_value;
   logic [STATUS_W-1:0] rsp_status;
   logic [COUNT_W-1:0]  rsp_count;

   deq_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_value  (req_tdata),
      .req_kind   (req_tuser),
      .cmd_valid  (cmd_valid),
      .cmd        (cmd),
      .cmd_ready  (cmd_ready)
   );

   deq_back #(
      .DEPTH (DEPTH)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .cmd_valid   (cmd_valid),
      .cmd         (cmd),
      .cmd_ready   (cmd_ready),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp_value   (rsp_value),
      .rsp_status  (rsp_status),
      .rsp_count   (rsp_count),
      .rsp_last    (rsp_tlast)
   );

   deq_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Pack result fields, lowest first
   assign rsp_tdata = {rsp_count, rsp_status, rsp_value};

endmodule

`default_nettype wire
